@@ rtl/bmrs_pkg.sv @@
// Shared types and constants for the bitmap run scanner.
// Used by every module of the block; depends on nothing.
package bmrs_pkg;

  localparam int CAPACITY    = 4096;
  localparam int WORD_BITS   = 64;
  localparam int WORD_COUNT  = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W       = 13;
  localparam int OFF_W       = $clog2(WORD_BITS);
  localparam int WADDR_W     = $clog2(WORD_COUNT);
  localparam int CWORD_W     = IDX_W - OFF_W;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_TEST      = 3'd0,
    ACT_SET       = 3'd1,
    ACT_CLEAR     = 3'd2,
    ACT_RUN_ONES  = 3'd3,
    ACT_RUN_ZEROS = 3'd4,
    ACT_FIND_ZERO = 3'd5
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH = 1'b0,
    REG_FIXED  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } back_state_t;

  // Classified request handed from front to back.
  typedef struct packed {
    action_t              action;
    logic [IDX_W-1:0]     start;
    logic [IDX_W-1:0]     stop;      // clamped exclusive end of the scan
    logic [IDX_W-1:0]     len;       // bits in use, clamped to capacity
    logic                 want;      // bit value a scan keeps running over
    logic                 in_range;  // start below len
    logic                 empty;     // scan has nothing to look at
  } cmd_t;

endpackage

@@ rtl/bitmap_run_scanner_unit.sv @@
// Top level of the bitmap run scanner.
// Depends on bmrs_pkg, bmrs_front, bmrs_queue and bmrs_back.
//
// The block keeps a 4096-bit map in a 64-word by 64-bit memory, cleared at
// reset through one valid flag per word (no clearing pass, items are taken
// right out of reset). Each word accepted on the input channel tests, sets or
// clears one bit, counts a run of ones or zeros from start_index up to a
// clamped stop_index, or finds the first zero at or after start_index. Bits at
// or beyond length_in_use read as zero; setting one raises out_of_range and
// leaves the map alone. The front end classifies each word and clamps its
// indexes, then a two-entry queue hands it to the scan engine, so the input
// keeps accepting while the engine works or while a result waits on the
// output register. A scan crosses the map one 64-bit word at a time: the
// engine reads one memory word per cycle and runs it through a 64-bit
// priority encoder. Write configuration only while the block is idle.
module bitmap_run_scanner_unit import bmrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           action,
  input  logic [IDX_W-1:0]     start_index,
  input  logic [IDX_W-1:0]     stop_index,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 bit_value,
  output logic [IDX_W-1:0]     answer,
  output logic                 out_of_range
);

  cmd_t cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic not_empty;

  // Classify and clamp the incoming word.
  bmrs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .start_index (start_index),
    .stop_index  (stop_index),
    .q_full      (q_full),
    .push        (push),
    .cmd         (cmd)
  );

  // Hold requests until the engine is free.
  bmrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .cmd_in    (cmd),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  // Carry out requests against the bit map and register the result.
  bmrs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .not_empty    (not_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bit_value    (bit_value),
    .answer       (answer),
    .out_of_range (out_of_range)
  );

endmodule

@@ rtl/bmrs_front.sv @@
// Front end: configuration registers, input acceptance and request classification.
// Depends on bmrs_pkg.
module bmrs_front import bmrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           action,
  input  logic [IDX_W-1:0]     start_index,
  input  logic [IDX_W-1:0]     stop_index,
  input  logic                 q_full,
  output logic                 push,
  output cmd_t                 cmd
);

  logic [IDX_W-1:0] length_in_use;
  logic             fixed_length_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_in_use     <= IDX_W'(CAPACITY);
      fixed_length_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_LENGTH: length_in_use     <= cfg_wdata[IDX_W-1:0];
        REG_FIXED:  fixed_length_mode <= cfg_wdata[0];
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    logic [IDX_W-1:0] cap;
    logic [IDX_W-1:0] len;
    logic [IDX_W-1:0] end_c;
    action_t          act;
    cap   = IDX_W'(CAPACITY);
    len   = (length_in_use > cap) ? cap : length_in_use;
    end_c = (stop_index > cap) ? cap : stop_index;
    if (fixed_length_mode && end_c > len) begin
      end_c = len;
    end
    act          = action_t'(action);
    cmd.action   = act;
    cmd.start    = start_index;
    cmd.len      = len;
    cmd.in_range = start_index < len;
    cmd.want     = (act == ACT_RUN_ONES) || (act == ACT_FIND_ZERO);
    // find-first-zero is a ones run that ends at the length in use
    cmd.stop     = (act == ACT_FIND_ZERO) ? len : end_c;
    cmd.empty    = start_index >= cmd.stop;
  end

endmodule

@@ rtl/bmrs_queue.sv @@
// Short request queue between the front end and the scan engine.
// Depends on bmrs_pkg.
module bmrs_queue import bmrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd_in,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic not_empty
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/bmrs_back.sv @@
// Back end: bit map memory, word-at-a-time scan engine and result register.
// Depends on bmrs_pkg.
module bmrs_back import bmrs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             head,
  input  logic             not_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             bit_value,
  output logic [IDX_W-1:0] answer,
  output logic             out_of_range
);

  localparam logic [WORD_BITS-1:0] ONES = '1;
  localparam logic [WORD_BITS-1:0] LSB  = WORD_BITS'(1);

  function automatic logic [OFF_W-1:0] first_set(input logic [WORD_BITS-1:0] x);
    logic [OFF_W-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (x[i]) p = OFF_W'(i);
    end
    return p;
  endfunction

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] row_valid;
  logic [WADDR_W-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_row_valid;
  logic                 wr_en;
  logic [WADDR_W-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  back_state_t          state, state_next;
  cmd_t                 op;
  logic [CWORD_W-1:0]   cur_word, cur_word_next;
  logic [OFF_W-1:0]     cur_off, cur_off_next;
  logic                 out_valid_next;
  logic                 bit_value_next;
  logic [IDX_W-1:0]     answer_next;
  logic                 out_of_range_next;

  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] lmask;
  logic [WORD_BITS-1:0] emask;
  logic [WORD_BITS-1:0] hits;
  logic [CWORD_W-1:0]   lw;
  logic [CWORD_W-1:0]   ew;
  logic [CWORD_W-1:0]   nxt_word;
  logic [OFF_W-1:0]     bit_off;
  logic [IDX_W-1:0]     pos;
  logic                 found;
  logic                 done;

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data      <= mem[rd_addr];
    rd_row_valid <= row_valid[rd_addr];
  end

  // Rows never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op <= head;
    end
    cur_word     <= cur_word_next;
    cur_off      <= cur_off_next;
    bit_value    <= bit_value_next;
    answer       <= answer_next;
    out_of_range <= out_of_range_next;
  end

  // Per-word view of the scan.
  always_comb begin
    word     = rd_row_valid ? rd_data : '0;
    bit_off  = op.start[OFF_W-1:0];
    wr_addr  = op.start[OFF_W +: WADDR_W];
    lw       = op.len[IDX_W-1:OFF_W];
    ew       = op.stop[IDX_W-1:OFF_W];
    nxt_word = cur_word + 1'b1;
    if (cur_word < lw) begin
      lmask = ONES;
    end else if (cur_word == lw) begin
      lmask = ~(ONES << op.len[OFF_W-1:0]);
    end else begin
      lmask = '0;
    end
    if (cur_word < ew) begin
      emask = '0;
    end else if (cur_word == ew) begin
      emask = ONES << op.stop[OFF_W-1:0];
    end else begin
      emask = ONES;
    end
    // a hit is a bit that breaks the run, or the end of the scan window
    hits  = ((op.want ? ~(word & lmask) : (word & lmask)) | emask) & (ONES << cur_off);
    found = |hits;
    pos   = {cur_word, first_set(hits)};
  end

  always_comb begin
    state_next        = state;
    pop               = 1'b0;
    rd_addr           = cur_word[WADDR_W-1:0];
    wr_en             = 1'b0;
    wr_data           = word;
    cur_word_next     = cur_word;
    cur_off_next      = cur_off;
    out_valid_next    = out_valid && !out_ready;
    bit_value_next    = bit_value;
    answer_next       = answer;
    out_of_range_next = out_of_range;
    done              = 1'b0;
    unique case (state)
      ST_IDLE: begin
        rd_addr = head.start[OFF_W +: WADDR_W];
        if (not_empty && (!out_valid || out_ready)) begin
          pop           = 1'b1;
          state_next    = ST_EXEC;
          cur_word_next = head.start[IDX_W-1:OFF_W];
          cur_off_next  = head.start[OFF_W-1:0];
        end
      end
      ST_EXEC: begin
        done              = 1'b1;
        bit_value_next    = 1'b0;
        answer_next       = '0;
        out_of_range_next = 1'b0;
        unique case (op.action)
          ACT_TEST: begin
            bit_value_next = op.in_range && word[bit_off];
          end
          ACT_SET: begin
            if (op.in_range) begin
              wr_en   = 1'b1;
              wr_data = word | (LSB << bit_off);
            end else begin
              out_of_range_next = 1'b1;
            end
          end
          ACT_CLEAR: begin
            if (op.in_range) begin
              wr_en   = 1'b1;
              wr_data = word & ~(LSB << bit_off);
            end
          end
          ACT_RUN_ONES, ACT_RUN_ZEROS, ACT_FIND_ZERO: begin
            if (op.empty) begin
              answer_next = (op.action == ACT_FIND_ZERO) ? op.start : '0;
            end else if (found) begin
              answer_next = (op.action == ACT_FIND_ZERO) ? pos : pos - op.start;
            end else begin
              // advance to the next word
              done          = 1'b0;
              cur_word_next = nxt_word;
              cur_off_next  = '0;
              rd_addr       = nxt_word[WADDR_W-1:0];
            end
          end
          default: ;
        endcase
        if (done) begin
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
    endcase
  end

`ifndef SYNTHESIS
  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == ST_EXEC)
    else $error("bit map written outside execute state");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE && not_empty))
    else $error("queue popped while busy or empty");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && state_next == ST_IDLE) |-> !out_valid)
    else $error("result finished while result register still full");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && !op.empty && (op.action == ACT_RUN_ONES ||
     op.action == ACT_RUN_ZEROS || op.action == ACT_FIND_ZERO))
    |-> cur_word <= op.stop[IDX_W-1:OFF_W])
    else $error("scan cursor ran past the end word");
`endif

endmodule

@@ tb/bitmap_run_scanner_unit_tb.sv @@
// Self-checking testbench for bitmap_run_scanner_unit: directed table, then random phases.
// Depends on bmrs_pkg and the bitmap_run_scanner_unit RTL only.
`timescale 1ns / 100ps

module bitmap_run_scanner_unit_tb import bmrs_pkg::*;;

  // Action codes the block must ignore: no change, all result fields zero.
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int PHASES           = 8;
  localparam int WORDS_PER_PHASE  = 250;
  localparam int PRESSURE_PHASE   = 4;
  localparam int RANDOM_LEN_PHASE = 5;
  localparam int HOLDOFF_CYCLES   = 500;
  localparam int SETTLE_CYCLES    = 80;   // outlasts the longest scan in the engine
  localparam int DIRECTED_COUNT   = 25;

  // Register settings per phase; phase 0 runs on the reset values.
  localparam logic [CFG_W-1:0] PHASE_LEN [PHASES] =
    '{13'd4096, 13'd100, 13'd0, 13'd8191, 13'd4096, 13'd0, 13'd64, 13'd4097};
  localparam bit PHASE_FIXED [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

  typedef struct packed {
    logic             bit_value;
    logic [IDX_W-1:0] answer;
    logic             out_of_range;
  } scan_result_t;

  typedef struct {
    logic [2:0]       act;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    bit               typed;   // use the typed result instead of the predictor
    scan_result_t     want;
  } directed_row_t;

  // Directed table, run right after reset (empty map, length 4096, fixed mode).
  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{ACT_TEST,      13'd0,    13'd0,    1'b1, '{1'b0, 13'd0,    1'b0}},
    '{ACT_TEST,      13'd4095, 13'd0,    1'b1, '{1'b0, 13'd0,    1'b0}},
    '{ACT_TEST,      13'd8191, 13'd8191, 1'b1, '{1'b0, 13'd0,    1'b0}},
    '{ACT_RUN_ZEROS, 13'd0,    13'd4096, 1'b1, '{1'b0, 13'd4096, 1'b0}},
    '{ACT_RUN_ZEROS, 13'd0,    13'd8191, 1'b1, '{1'b0, 13'd4096, 1'b0}},
    '{ACT_RUN_ONES,  13'd0,    13'd4096, 1'b1, '{1'b0, 13'd0,    1'b0}},
    '{ACT_FIND_ZERO, 13'd0,    13'd0,    1'b1, '{1'b0, 13'd0,    1'b0}},
    '{ACT_FIND_ZERO, 13'd8191, 13'd0,    1'b1, '{1'b0, 13'd8191, 1'b0}},
    '{ACT_SET,       13'd4096, 13'd0,    1'b1, '{1'b0, 13'd0,    1'b1}},
    '{ACT_SET,       13'd8191, 13'd8191, 1'b1, '{1'b0, 13'd0,    1'b1}},
    '{ACT_CLEAR,     13'd8191, 13'd0,    1'b1, '{1'b0, 13'd0,    1'b0}},
    '{ACT_SET,       13'd0,    13'd0,    1'b0, '0},
    '{ACT_SET,       13'd63,   13'd0,    1'b0, '0},
    '{ACT_SET,       13'd64,   13'd0,    1'b0, '0},
    '{ACT_SET,       13'd65,   13'd0,    1'b0, '0},
    '{ACT_SET,       13'd4095, 13'd0,    1'b0, '0},
    '{ACT_RUN_ONES,  13'd63,   13'd4096, 1'b0, '0},
    '{ACT_TEST,      13'd64,   13'd0,    1'b0, '0},
    '{ACT_RUN_ZEROS, 13'd100,  13'd50,   1'b1, '{1'b0, 13'd0,    1'b0}},
    '{ACT_SPARE_6,   13'd8191, 13'd8191, 1'b1, '{1'b0, 13'd0,    1'b0}},
    '{ACT_SPARE_7,   13'd4095, 13'd4096, 1'b1, '{1'b0, 13'd0,    1'b0}},
    '{ACT_FIND_ZERO, 13'd4095, 13'd0,    1'b0, '0},
    '{ACT_CLEAR,     13'd64,   13'd0,    1'b0, '0},
    '{ACT_RUN_ONES,  13'd63,   13'd8191, 1'b0, '0},
    '{ACT_FIND_ZERO, 13'd63,   13'd0,    1'b0, '0}
  };

  // Every input is known from time zero.
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr     = '0;
  logic [CFG_W-1:0]     cfg_wdata    = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [2:0]           action       = '0;
  logic [IDX_W-1:0]     start_index  = '0;
  logic [IDX_W-1:0]     stop_index   = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic                 bit_value;
  logic [IDX_W-1:0]     answer;
  logic                 out_of_range;

  bitmap_run_scanner_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .start_index  (start_index),
    .stop_index   (stop_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bit_value    (bit_value),
    .answer       (answer),
    .out_of_range (out_of_range)
  );

  always #5 clk = ~clk;

  // Shadow copy of the map and registers, advanced on each accepted request word.
  bit [WORD_BITS-1:0] shadow_map [WORD_COUNT];
  logic [CFG_W-1:0]   shadow_len   = 13'd4096;
  bit                 shadow_fixed = 1'b1;

  scan_result_t pending_results [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          holding_off    = 1'b0;
  int unsigned error_count    = 0;
  int unsigned requests_sent  = 0;
  int unsigned results_checked = 0;
  int unsigned oor_sets_seen  = 0;
  int unsigned longest_answer = 0;

  // Random request shaping: a hot window that sets and clears cluster in, plus
  // bursts of consecutive sets or clears that build long runs across words.
  int unsigned window_base = 0;
  int unsigned burst_left  = 0;
  int unsigned burst_next  = 0;
  logic [2:0]  burst_act   = ACT_SET;

  function automatic int unsigned usable_len();
    return (shadow_len > CAPACITY) ? CAPACITY : shadow_len;
  endfunction

  // Bits at or beyond the length in use read as zero.
  function automatic bit map_bit(int unsigned idx);
    if (idx >= usable_len())
      return 1'b0;
    return shadow_map[idx / WORD_BITS][idx % WORD_BITS];
  endfunction

  // Clamp the stop to capacity, and to the length in use in fixed mode, then
  // count matching bits from the start.
  function automatic int unsigned count_run(int unsigned from, int unsigned upto, bit want);
    int unsigned n;
    n = 0;
    if (upto > CAPACITY)
      upto = CAPACITY;
    if (shadow_fixed && upto > usable_len())
      upto = usable_len();
    while (from < upto && map_bit(from) == want) begin
      from++;
      n++;
    end
    return n;
  endfunction

  function automatic scan_result_t predict_request(logic [2:0] act, logic [IDX_W-1:0] first,
                                                   logic [IDX_W-1:0] last);
    scan_result_t r;
    int unsigned  len;
    int unsigned  idx;
    r   = '0;
    len = usable_len();
    idx = first;
    case (act)
      ACT_TEST: r.bit_value = map_bit(idx);
      ACT_SET: begin
        // out-of-range set: flag it, leave the map alone
        if (idx >= len)
          r.out_of_range = 1'b1;
        else
          shadow_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
      end
      ACT_CLEAR: begin
        if (idx < len)
          shadow_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
      end
      ACT_RUN_ONES:  r.answer = IDX_W'(count_run(idx, last, 1'b1));
      ACT_RUN_ZEROS: r.answer = IDX_W'(count_run(idx, last, 1'b0));
      ACT_FIND_ZERO: begin
        // a start at or past the length returns itself; no zero returns the length
        while (idx < len && map_bit(idx))
          idx++;
        r.answer = IDX_W'(idx);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void make_request(output logic [2:0] act, output logic [IDX_W-1:0] first,
                                       output logic [IDX_W-1:0] last);
    int unsigned lim;
    int unsigned roll;
    lim = (usable_len() < 64) ? 64 : usable_len();
    if ($urandom_range(99) < 2)
      window_base = $urandom_range(lim - 1);
    if (burst_left == 0 && $urandom_range(99) < 4) begin
      burst_left = $urandom_range(8, 150);
      burst_next = window_base + $urandom_range(63);
      burst_act  = ($urandom_range(3) == 0) ? ACT_CLEAR : ACT_SET;
    end
    if (burst_left != 0) begin
      act   = burst_act;
      first = IDX_W'(burst_next);
      burst_next++;
      burst_left--;
    end else begin
      roll = $urandom_range(99);
      if (roll < 25)      act = ACT_SET;
      else if (roll < 35) act = ACT_CLEAR;
      else if (roll < 45) act = ACT_TEST;
      else if (roll < 60) act = ACT_RUN_ONES;
      else if (roll < 75) act = ACT_RUN_ZEROS;
      else if (roll < 95) act = ACT_FIND_ZERO;
      else                act = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
      roll = $urandom_range(99);
      if (roll < 70)
        first = IDX_W'(window_base + $urandom_range(255));
      else if (roll < 85)
        first = IDX_W'(lim + $urandom_range(4) - 2);
      else
        first = IDX_W'($urandom_range(8191));
    end
    // stop index is random in every case, so its bits toggle even in bursts
    roll = $urandom_range(99);
    if (roll < 60)
      last = IDX_W'(first + $urandom_range(400));
    else if (roll < 75)
      last = IDX_W'(lim + $urandom_range(4) - 2);
    else
      last = IDX_W'($urandom_range(8191));
    // now and then a stop below the start
    if ($urandom_range(99) < 8)
      last = IDX_W'(first - $urandom_range(5));
  endfunction

  // Offer one request word, hold it until accepted, then log what it must return.
  task automatic send_request(input logic [2:0] act, input logic [IDX_W-1:0] first,
                              input logic [IDX_W-1:0] last, input bit typed,
                              input scan_result_t typed_want);
    scan_result_t predicted;
    int unsigned  gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    start_index <= first;
    stop_index  <= last;
    do @(posedge clk); while (!in_ready);
    predicted = predict_request(act, first, last);
    pending_results.push_back(typed ? typed_want : predicted);
    requests_sent++;
  endtask

  // Drop valid, wait out every result, then let the engine settle.
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (which == REG_LENGTH)
      shadow_len = value;
    else
      shadow_fixed = value[0];
  endtask

  function automatic void check_result();
    scan_result_t want;
    if (pending_results.size() == 0) begin
      $error("result word with no request pending: bit_value %0d answer %0d out_of_range %0d",
             bit_value, answer, out_of_range);
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    if (bit_value !== want.bit_value) begin
      $error("bit_value: expected %0d, got %0d", want.bit_value, bit_value);
      error_count++;
    end
    if (answer !== want.answer) begin
      $error("answer: expected %0d, got %0d", want.answer, answer);
      error_count++;
    end
    if (out_of_range !== want.out_of_range) begin
      $error("out_of_range: expected %0d, got %0d", want.out_of_range, out_of_range);
      error_count++;
    end
    results_checked++;
    if (want.out_of_range)
      oor_sets_seen++;
    if (want.answer > longest_answer)
      longest_answer = want.answer;
  endfunction

  // Result side: check each accepted word, then pick the next cycle's ready.
  // A hold-off forces ready low for a long stretch regardless of the stall rate.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      check_result();
    out_ready <= !holding_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [2:0]       act;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    logic [CFG_W-1:0] len_value;
    int unsigned      mode;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset settings, no idling.
    for (int i = 0; i < DIRECTED_COUNT; i++)
      send_request(directed_rows[i].act, directed_rows[i].first, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);
    finish_phase();

    for (int p = 0; p < PHASES; p++) begin
      // Reprogram only now, with the block drained.
      if (p != 0) begin
        len_value = (p == RANDOM_LEN_PHASE) ? CFG_W'($urandom_range(1, 4095)) : PHASE_LEN[p];
        write_reg(REG_LENGTH, len_value);
        // upper data bits are ignored by the mode register; toggle them anyway
        write_reg(REG_FIXED, {CFG_W'($urandom_range(4095)) << 1} | CFG_W'(PHASE_FIXED[p]));
      end
      mode = p % 4;
      send_idle_pct  <= (mode == 1) ? 76 : (mode == 3) ? 34 : 0;
      recv_stall_pct <= (mode == 2) ? 76 : (mode == 3) ? 34 : 0;
      window_base = $urandom_range(((usable_len() < 64) ? 64 : usable_len()) - 1);
      burst_left  = 0;

      // Back-pressure: stall the result side long enough to fill the queue
      // while requests keep coming at full rate.
      if (p == PRESSURE_PHASE) begin
        fork
          begin
            holding_off <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clk);
            holding_off <= 1'b0;
          end
        join_none
      end

      repeat (WORDS_PER_PHASE) begin
        make_request(act, first, last);
        send_request(act, first, last, 1'b0, '0);
      end
      finish_phase();
    end

    $display("Checked %0d result words for %0d requests over %0d register settings",
             results_checked, requests_sent, PHASES);
    $display("Saw %0d out-of-range sets; longest run or find answer was %0d",
             oor_sets_seen, longest_answer);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
